/* hw/rtl/anisotropic_tensor_rotation_unit_macros.svh */
// Assertion macros shared by the tensor rotation RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ANISOTROPIC_TENSOR_ROTATION_UNIT_MACROS_SVH
`define ANISOTROPIC_TENSOR_ROTATION_UNIT_MACROS_SVH

// check a condition in the same cycle
`define ATRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the next cycle
`define ATRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/atru_pkg.sv */
// Shared types, constants and arithmetic helpers of the tensor rotation unit.
// No dependencies.
package atru_pkg;

    localparam int ANG_W     = 16;
    localparam int PIN_W     = 32;
    localparam int Q_W       = 18;
    localparam int CW        = 34;
    localparam int TABLE_LEN = 24;
    localparam int PRODW     = Q_W + PIN_W + 1;
    localparam int SUMW      = PRODW + 2;
    localparam int TOUT_W    = 33;

    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic [16:0] HALF_TURN      = 17'd23040;
    localparam logic [16:0] QUARTER_TURN   = 17'd11520;

    localparam logic signed [CW-1:0]  CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0]  ONE_WIDE        = 34'sd65536;
    localparam logic signed [CW-1:0]  ROUND_Q30       = 34'sd8192;
    localparam logic signed [Q_W-1:0] ONE_Q16         = 18'sd65536;

    localparam int PAIR_ROW [6] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_COL [6] = '{0, 1, 2, 1, 2, 2};
    localparam bit PAIR_DIAG [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef logic signed [Q_W-1:0] q16_t;

    typedef struct packed {
        logic [PIN_W-1:0] perm_minor;
        logic [PIN_W-1:0] perm_middle;
        logic [PIN_W-1:0] perm_major;
        logic [ANG_W-1:0] angle_three;
        logic [ANG_W-1:0] angle_two;
        logic [ANG_W-1:0] angle_one;
    } in_item_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic q16_t clamp_q16(input logic signed [CW-1:0] v);
        q16_t r;
        if (v > ONE_WIDE)
        begin
            r = ONE_Q16;
        end
        else if (v < -ONE_WIDE)
        begin
            r = -ONE_Q16;
        end
        else
        begin
            r = q16_t'(v);
        end
        return r;
    endfunction

    function automatic q16_t qmul(input q16_t a, input q16_t b);
        logic signed [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + 36'sd32768;
        return q16_t'(p >>> 16);
    endfunction

endpackage

/* hw/rtl/anisotropic_tensor_rotation_unit.sv */
// Rotated symmetric permeability tensor unit: one mesh element per item.
// Channels: s_* carries angles and principal permeabilities, m_* carries the
// six distinct tensor entries. Both are valid/ready streams; an item moves
// when tvalid and tready are high at a rising clock edge.
// Pipeline: min(CORDIC_STEPS, 24) + 8 register stages (24 at the default):
// fold, one CORDIC step per stage, round, two matrix product stages,
// weight, multiply, sum and saturate.
// Throughput: one item per cycle unless the receiver stalls; every stage is
// registered and each unit has its own multipliers, so nothing is shared between items.
// Reset clears all valid bits; the block then takes an item at once.
// When the receiver stalls, the output holds and stages fill behind it;
// s_tready drops only once every stage holds an item.
// Depends on atru_pkg, atru_sincos, atru_matrix, atru_weigh and the macro header.
`include "anisotropic_tensor_rotation_unit_macros.svh"

module anisotropic_tensor_rotation_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int PERM_BITS    = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle_one[15:0], angle_two[31:16], angle_three[47:32], perm_major[79:48],
    // perm_middle[111:80], perm_minor[143:112]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tensor_xx[31:0], tensor_xy[64:32], tensor_xz[97:65], tensor_yy[129:98],
    // tensor_yz[162:130], tensor_zz[194:163], zero[199:195]
    output logic [199:0] m_tdata
);

    localparam int NSTEP = (CORDIC_STEPS < atru_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : atru_pkg::TABLE_LEN;
    localparam int L     = NSTEP + 8;
    localparam int PIN_W = atru_pkg::PIN_W;

    atru_pkg::in_item_t          item;
    logic [L-1:0]                vld_reg;
    logic [L-1:0]                vld_next;
    logic [L:0]                  en;
    atru_pkg::q16_t              s1, c1, s2, c2, s3, c3;
    atru_pkg::q16_t              r [3][3];
    logic [PIN_W-1:0]            pd_reg [0:NSTEP+3][3];
    logic [atru_pkg::TOUT_W-1:0] tensor [6];

    assign item = atru_pkg::in_item_t'(s_tdata);

    // advance a stage when it is empty or the next one advances
    assign en[L] = m_tready;
    for (genvar i = 0; i < L; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    assign vld_next = {vld_reg[L-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < L; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[L-1];

    atru_sincos #(.NSTEP(NSTEP)) u_sc1 (
        .clk   (clk),
        .en    (en[NSTEP+1:0]),
        .angle (signed'(item.angle_one)),
        .sin_q (s1),
        .cos_q (c1)
    );

    atru_sincos #(.NSTEP(NSTEP)) u_sc2 (
        .clk   (clk),
        .en    (en[NSTEP+1:0]),
        .angle (signed'(item.angle_two)),
        .sin_q (s2),
        .cos_q (c2)
    );

    atru_sincos #(.NSTEP(NSTEP)) u_sc3 (
        .clk   (clk),
        .en    (en[NSTEP+1:0]),
        .angle (signed'(item.angle_three)),
        .sin_q (s3),
        .cos_q (c3)
    );

    // hold permeabilities alongside the angle stages
    for (genvar i = 0; i <= NSTEP + 3; i++)
    begin : g_pd
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                if (i == 0)
                begin
                    pd_reg[i][0] <= item.perm_major;
                    pd_reg[i][1] <= item.perm_middle;
                    pd_reg[i][2] <= item.perm_minor;
                end
                else
                begin
                    pd_reg[i] <= pd_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    atru_matrix u_mat (
        .clk (clk),
        .en  (en[NSTEP+3:NSTEP+2]),
        .s1  (s1),
        .c1  (c1),
        .s2  (s2),
        .c2  (c2),
        .s3  (s3),
        .c3  (c3),
        .r   (r)
    );

    atru_weigh #(.PERM_BITS(PERM_BITS)) u_wgh (
        .clk    (clk),
        .en     (en[NSTEP+7:NSTEP+4]),
        .r      (r),
        .perm   (pd_reg[NSTEP+3]),
        .tensor (tensor)
    );

    assign m_tdata = {5'b0,
                      tensor[5][31:0],
                      tensor[4],
                      tensor[3][31:0],
                      tensor[2],
                      tensor[1],
                      tensor[0][31:0]};

    `ATRU_ASSERT_SAME(a_stall_only_full, !s_tready, (&vld_reg) && !m_tready,
        "input stalled while a stage was free")
    `ATRU_ASSERT_NEXT(a_count_up, s_tvalid && s_tready && !(m_tvalid && m_tready),
        $countones(vld_reg) == $past($countones(vld_reg)) + 1,
        "item count did not grow on accept")
    `ATRU_ASSERT_NEXT(a_count_down, m_tvalid && m_tready && !(s_tvalid && s_tready),
        $countones(vld_reg) + 1 == $past($countones(vld_reg)),
        "item count did not shrink on delivery")

endmodule

/* hw/rtl/atru_sincos.sv */
// Sine and cosine of one Q7 degree angle: fold, one CORDIC step per stage, round.
// Depends on atru_pkg.
module atru_sincos #(
    parameter int NSTEP = 16
) (
    input  logic                       clk,
    input  logic [NSTEP+1:0]           en,
    input  logic signed [15:0]         angle,
    output atru_pkg::q16_t             sin_q,
    output atru_pkg::q16_t             cos_q
);

    localparam int CW = atru_pkg::CW;

    logic signed [16:0]   a_ext;
    logic [16:0]          mag;
    logic [16:0]          mag_f;
    logic                 sflip;
    logic                 cflip;
    logic [41:0]          zprod;
    logic signed [CW-1:0] z_fold;

    logic signed [CW-1:0] x_reg [1:NSTEP];
    logic signed [CW-1:0] y_reg [1:NSTEP];
    logic signed [CW-1:0] z_reg [0:NSTEP];
    logic                 sneg_reg [0:NSTEP];
    logic                 cneg_reg [0:NSTEP];
    atru_pkg::q16_t       sin_reg;
    atru_pkg::q16_t       cos_reg;
    atru_pkg::q16_t       sin_next;
    atru_pkg::q16_t       cos_next;

    // fold into the first quadrant
    always_comb
    begin
        a_ext = 17'(angle);
        mag   = a_ext[16] ? 17'(-a_ext) : 17'(a_ext);
        sflip = 1'b0;
        cflip = 1'b0;
        mag_f = mag;
        if (mag > atru_pkg::HALF_TURN)
        begin
            mag_f = mag - atru_pkg::HALF_TURN;
            sflip = 1'b1;
            cflip = 1'b1;
        end
        else if (mag > atru_pkg::QUARTER_TURN)
        begin
            mag_f = atru_pkg::HALF_TURN - mag;
            cflip = 1'b1;
        end
        zprod  = 42'(mag_f) * 42'(atru_pkg::DEG_TO_RAD_Q30) + 42'd64;
        z_fold = signed'(zprod[CW+6:7]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            z_reg[0]    <= z_fold;
            sneg_reg[0] <= a_ext[16] ^ sflip;
            cneg_reg[0] <= cflip;
        end
    end

    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_step
        logic signed [CW-1:0] xp;
        logic signed [CW-1:0] yp;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;

        if (k == 1)
        begin : g_first
            assign xp = atru_pkg::CORDIC_GAIN_Q30;
            assign yp = '0;
        end
        else
        begin : g_rest
            assign xp = x_reg[k-1];
            assign yp = y_reg[k-1];
        end

        always_comb
        begin
            if (!z_reg[k-1][CW-1])
            begin
                x_next = xp - (yp >>> (k-1));
                y_next = yp + (xp >>> (k-1));
                z_next = z_reg[k-1] - atru_pkg::atan_q30(k-1);
            end
            else
            begin
                x_next = xp + (yp >>> (k-1));
                y_next = yp - (xp >>> (k-1));
                z_next = z_reg[k-1] + atru_pkg::atan_q30(k-1);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k]    <= x_next;
                y_reg[k]    <= y_next;
                z_reg[k]    <= z_next;
                sneg_reg[k] <= sneg_reg[k-1];
                cneg_reg[k] <= cneg_reg[k-1];
            end
        end
    end

    // round to Q1.16, clamp, restore quadrant
    always_comb
    begin
        sin_next = atru_pkg::clamp_q16((y_reg[NSTEP] + atru_pkg::ROUND_Q30) >>> 14);
        cos_next = atru_pkg::clamp_q16((x_reg[NSTEP] + atru_pkg::ROUND_Q30) >>> 14);
        if (sneg_reg[NSTEP])
        begin
            sin_next = -sin_next;
        end
        if (cneg_reg[NSTEP])
        begin
            cos_next = -cos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTEP+1])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

/* hw/rtl/atru_matrix.sv */
// Rotation matrix from three sine/cosine pairs in two product stages.
// Depends on atru_pkg.
module atru_matrix (
    input  logic           clk,
    input  logic [1:0]     en,
    input  atru_pkg::q16_t s1,
    input  atru_pkg::q16_t c1,
    input  atru_pkg::q16_t s2,
    input  atru_pkg::q16_t c2,
    input  atru_pkg::q16_t s3,
    input  atru_pkg::q16_t c3,
    output atru_pkg::q16_t r [3][3]
);

    localparam int CW = atru_pkg::CW;

    atru_pkg::q16_t c1c2_reg, c1s2_reg, s1c2_reg, s1s2_reg, s1c3_reg;
    atru_pkg::q16_t s1s3_reg, c1c3_reg, c1s3_reg, c2s3_reg, c2c3_reg;
    atru_pkg::q16_t s2_reg, s3_reg, c3_reg;
    atru_pkg::q16_t r_reg [3][3];
    atru_pkg::q16_t r_next [3][3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1c2_reg <= atru_pkg::qmul(c1, c2);
            c1s2_reg <= atru_pkg::qmul(c1, s2);
            s1c2_reg <= atru_pkg::qmul(s1, c2);
            s1s2_reg <= atru_pkg::qmul(s1, s2);
            s1c3_reg <= atru_pkg::qmul(s1, c3);
            s1s3_reg <= atru_pkg::qmul(s1, s3);
            c1c3_reg <= atru_pkg::qmul(c1, c3);
            c1s3_reg <= atru_pkg::qmul(c1, s3);
            c2s3_reg <= atru_pkg::qmul(c2, s3);
            c2c3_reg <= atru_pkg::qmul(c2, c3);
            s2_reg   <= s2;
            s3_reg   <= s3;
            c3_reg   <= c3;
        end
    end

    always_comb
    begin
        r_next[0][0] = c1c2_reg;
        r_next[0][1] = atru_pkg::clamp_q16(-CW'(atru_pkg::qmul(c1s2_reg, s3_reg))
                                           - CW'(s1c3_reg));
        r_next[0][2] = atru_pkg::clamp_q16(-CW'(atru_pkg::qmul(c1s2_reg, c3_reg))
                                           + CW'(s1s3_reg));
        r_next[1][0] = s1c2_reg;
        r_next[1][1] = atru_pkg::clamp_q16(-CW'(atru_pkg::qmul(s1s2_reg, s3_reg))
                                           + CW'(c1c3_reg));
        r_next[1][2] = atru_pkg::clamp_q16(-CW'(atru_pkg::qmul(s1s2_reg, c3_reg))
                                           - CW'(c1s3_reg));
        r_next[2][0] = s2_reg;
        r_next[2][1] = c2s3_reg;
        r_next[2][2] = c2c3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

/* hw/rtl/atru_weigh.sv */
// Weighted sums of matrix row products and principal values, rounded and saturated.
// Depends on atru_pkg; the last stage is the output register.
module atru_weigh #(
    parameter int PERM_BITS = 32
) (
    input  logic                                clk,
    input  logic [3:0]                          en,
    input  atru_pkg::q16_t                      r [3][3],
    input  logic [atru_pkg::PIN_W-1:0]          perm [3],
    output logic [atru_pkg::TOUT_W-1:0]         tensor [6]
);

    localparam int PIN_W = atru_pkg::PIN_W;
    localparam int PRODW = atru_pkg::PRODW;
    localparam int SUMW  = atru_pkg::SUMW;
    localparam int PMW   = (PERM_BITS < PIN_W) ? PERM_BITS : PIN_W;
    localparam logic signed [SUMW-1:0] PMAX = (SUMW'(1) << PERM_BITS) - SUMW'(1);

    atru_pkg::q16_t              w_reg [6][3];
    logic [PIN_W-1:0]            p_reg [3];
    logic signed [PRODW-1:0]     prod_reg [6][3];
    logic signed [SUMW-1:0]      sum_reg [6];
    logic [atru_pkg::TOUT_W-1:0] t_reg [6];
    logic signed [SUMW-1:0]      sum_next [6];
    logic signed [SUMW-1:0]      sat_next [6];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 6; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    w_reg[j][k] <= atru_pkg::qmul(r[atru_pkg::PAIR_ROW[j]][k],
                                                  r[atru_pkg::PAIR_COL[j]][k]);
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= PIN_W'(perm[k][PMW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < 6; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[j][k] <= PRODW'(w_reg[j][k]) * signed'(PRODW'(p_reg[k]));
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            sum_next[j] = (SUMW'(prod_reg[j][0]) + SUMW'(prod_reg[j][1])
                           + SUMW'(prod_reg[j][2]) + SUMW'(32768)) >>> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sum_reg <= sum_next;
        end
    end

    // saturate: diagonal to [0, max], off-diagonal to [-max, max]
    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            sat_next[j] = sum_reg[j];
            if (sum_reg[j] > PMAX)
            begin
                sat_next[j] = PMAX;
            end
            else if (atru_pkg::PAIR_DIAG[j] && sum_reg[j] < SUMW'(0))
            begin
                sat_next[j] = '0;
            end
            else if (!atru_pkg::PAIR_DIAG[j] && sum_reg[j] < -PMAX)
            begin
                sat_next[j] = -PMAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 6; j++)
            begin
                t_reg[j] <= sat_next[j][atru_pkg::TOUT_W-1:0];
            end
        end
    end

    assign tensor = t_reg;

endmodule

/* sim/tb_anisotropic_tensor_rotation_unit.sv */
// Testbench for the anisotropic tensor rotation unit: drives element items,
// predicts the rotated tensor with a local fixed-point model, checks every result.
// Depends on atru_pkg and the anisotropic_tensor_rotation_unit RTL.
`timescale 1ns / 100ps

module tb_anisotropic_tensor_rotation_unit;

    localparam int STEPS      = 16;
    localparam int PBITS      = 32;
    localparam int WATCHDOG   = 20000;
    localparam int DRAIN      = 64;
    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    typedef struct {
        logic [31:0] xx;
        logic [32:0] xy;
        logic [32:0] xz;
        logic [31:0] yy;
        logic [32:0] yz;
        logic [31:0] zz;
    } tensor_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [199:0] m_tdata;

    tensor_t tensor_q[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;
    int      hold_cycles;
    int      errors;
    int      items_sent;
    int      results_seen;
    int      quiet_cycles;

    anisotropic_tensor_rotation_unit #(
        .CORDIC_STEPS(STEPS),
        .PERM_BITS(PBITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_mul(longint a, longint b);
        return floor_shr(a * b + 32768, 16);
    endfunction

    function automatic void angle_sincos(input logic [15:0] raw, output longint sn,
                                         output longint cs);
        longint a;
        longint m;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     neg;
        bit     sflip;
        bit     cflip;
        a = longint'($signed(raw));
        neg = a < 0;
        m = neg ? -a : a;
        sflip = 0;
        cflip = 0;
        if (m > 23040)
        begin
            m -= 23040;
            sflip = 1;
            cflip = 1;
        end
        else if (m > 11520)
        begin
            m = 23040 - m;
            cflip = 1;
        end
        z = (m * 18740330 + 64) >>> 7;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= ATAN_TAB[i];
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += ATAN_TAB[i];
            end
            x = nx;
        end
        x = clip(floor_shr(x + 8192, 14), -65536, 65536);
        y = clip(floor_shr(y + 8192, 14), -65536, 65536);
        if (sflip != neg)
            y = -y;
        if (cflip)
            x = -x;
        sn = y;
        cs = x;
    endfunction

    function automatic longint weighted_sum(longint ra[3], longint rb[3], longint p[3]);
        longint hi;
        longint lo;
        longint w;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++)
        begin
            w = round_mul(ra[k], rb[k]);
            hi += w * (p[k] >>> 24);
            lo += w * (p[k] & 64'hFFFFFF);
        end
        return hi * 256 + floor_shr(lo + 32768, 16);
    endfunction

    function automatic tensor_t rotate_tensor(atru_pkg::in_item_t it);
        longint  s1, c1, s2, c2, s3, c3;
        longint  r0[3];
        longint  r1[3];
        longint  r2[3];
        longint  p[3];
        longint  pmax;
        tensor_t t;
        pmax = (longint'(1) << PBITS) - 1;
        angle_sincos(it.angle_one, s1, c1);
        angle_sincos(it.angle_two, s2, c2);
        angle_sincos(it.angle_three, s3, c3);
        p[0] = longint'(it.perm_major) & pmax;
        p[1] = longint'(it.perm_middle) & pmax;
        p[2] = longint'(it.perm_minor) & pmax;
        r0[0] = round_mul(c1, c2);
        r0[1] = -round_mul(round_mul(c1, s2), s3) - round_mul(s1, c3);
        r0[2] = -round_mul(round_mul(c1, s2), c3) + round_mul(s1, s3);
        r1[0] = round_mul(s1, c2);
        r1[1] = -round_mul(round_mul(s1, s2), s3) + round_mul(c1, c3);
        r1[2] = -round_mul(round_mul(s1, s2), c3) - round_mul(c1, s3);
        r2[0] = s2;
        r2[1] = round_mul(c2, s3);
        r2[2] = round_mul(c2, c3);
        for (int k = 0; k < 3; k++)
        begin
            r0[k] = clip(r0[k], -65536, 65536);
            r1[k] = clip(r1[k], -65536, 65536);
            r2[k] = clip(r2[k], -65536, 65536);
        end
        t.xx = 32'(clip(weighted_sum(r0, r0, p), 0, pmax));
        t.xy = 33'(clip(weighted_sum(r0, r1, p), -pmax, pmax));
        t.xz = 33'(clip(weighted_sum(r0, r2, p), -pmax, pmax));
        t.yy = 32'(clip(weighted_sum(r1, r1, p), 0, pmax));
        t.yz = 33'(clip(weighted_sum(r1, r2, p), -pmax, pmax));
        t.zz = 32'(clip(weighted_sum(r2, r2, p), 0, pmax));
        return t;
    endfunction

    task automatic send_element(input atru_pkg::in_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tensor_q = {tensor_q, rotate_tensor(it)};
        items_sent++;
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(46080)) - 23040);
            2:       return 16'($signed($urandom_range(8)) - 4);
            3:       return 16'($signed($urandom_range(4)) - 2 + 11520 *
                                $signed($urandom_range(4) - 2));
            default: return 16'($signed($urandom_range(46080)) - 23040);
        endcase
    endfunction

    function automatic logic [31:0] rand_perm();
        case ($urandom_range(4))
            0:       return 32'hFFFFFFFF - $urandom_range(3);
            1:       return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic atru_pkg::in_item_t rand_element();
        atru_pkg::in_item_t it;
        it.angle_one   = rand_angle();
        it.angle_two   = rand_angle();
        it.angle_three = rand_angle();
        it.perm_major  = rand_perm();
        it.perm_middle = rand_perm();
        it.perm_minor  = rand_perm();
        return it;
    endfunction

    function automatic atru_pkg::in_item_t make_element(logic [15:0] a1, logic [15:0] a2,
                                                        logic [15:0] a3, logic [31:0] p1,
                                                        logic [31:0] p2, logic [31:0] p3);
        atru_pkg::in_item_t it;
        it.angle_one   = a1;
        it.angle_two   = a2;
        it.angle_three = a3;
        it.perm_major  = p1;
        it.perm_middle = p2;
        it.perm_minor  = p3;
        return it;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tensor_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [15:0] ang [12] = '{16'h0000, 16'd23040, -16'sd23040, 16'd11520,
                                  -16'sd11520, 16'h7FFF, 16'h8000, 16'hFFFF,
                                  16'd23041, -16'sd23041, 16'd5760, 16'd11521};
        for (int i = 0; i < 12; i++)
            send_element(make_element(ang[i], ang[(i + 3) % 12], ang[(i + 7) % 12],
                                      32'hFFFFFFFF, 32'h80000000, 32'd1));
        send_element(make_element(0, 0, 0, 0, 0, 0));
        send_element(make_element(16'd5760, 16'd5760, 16'd5760,
                                  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send_element(make_element(16'd5760, 16'd11520, 16'd5760,
                                  32'hFFFFFFFF, 32'd0, 32'd0));
        send_element(make_element(16'd5760, 0, 0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF));
        send_element(make_element(16'h5555, 16'hAAAA, 16'h5555,
                                  32'h55555555, 32'hAAAAAAAA, 32'h55555555));
        send_element(make_element(16'hAAAA, 16'h5555, 16'hAAAA,
                                  32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_element(rand_element());
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 200;
        hold_off       = 1'b1;
        for (int i = 0; i < 60; i++)
            send_element(rand_element());
        wait_drained();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_off <= 1'b0;
        end
        else if (hold_off)
        begin
            m_tready <= 1'b0;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else
                hold_off <= 1'b0;
        end
        else
        begin
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tensor_t exp_t;
        if (rst_n)
        begin
            quiet_cycles <= (s_tvalid && s_tready) || (m_tvalid && m_tready) ? 0 :
                            quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (tensor_q.size() == 0)
                begin
                    $error("unexpected result item: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_t = tensor_q.pop_front();
                    if (m_tdata[31:0] !== exp_t.xx)
                    begin
                        $error("tensor_xx exp %h got %h", exp_t.xx, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[64:32] !== exp_t.xy)
                    begin
                        $error("tensor_xy exp %h got %h", exp_t.xy, m_tdata[64:32]);
                        errors++;
                    end
                    if (m_tdata[97:65] !== exp_t.xz)
                    begin
                        $error("tensor_xz exp %h got %h", exp_t.xz, m_tdata[97:65]);
                        errors++;
                    end
                    if (m_tdata[129:98] !== exp_t.yy)
                    begin
                        $error("tensor_yy exp %h got %h", exp_t.yy, m_tdata[129:98]);
                        errors++;
                    end
                    if (m_tdata[162:130] !== exp_t.yz)
                    begin
                        $error("tensor_yz exp %h got %h", exp_t.yz, m_tdata[162:130]);
                        errors++;
                    end
                    if (m_tdata[194:163] !== exp_t.zz)
                    begin
                        $error("tensor_zz exp %h got %h", exp_t.zz, m_tdata[194:163]);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("timeout with %0d results outstanding", tensor_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        errors         = 0;
        items_sent     = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(200, 0, 0);
        test_backpressure();
        test_random(180, 74, 0);
        test_random(180, 0, 74);
        test_random(180, 27, 27);
        wait_drained();
        repeat (DRAIN) @(posedge clk);
        $display("sent %0d elements, checked %0d tensors across idle, stall and hold-off phases",
                 items_sent, results_seen);
        if (errors == 0 && tensor_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/atru_pkg.sv
hw/rtl/atru_sincos.sv
hw/rtl/atru_matrix.sv
hw/rtl/atru_weigh.sv
hw/rtl/anisotropic_tensor_rotation_unit.sv
sim/tb_anisotropic_tensor_rotation_unit.sv
